### sv/fss_pkg.sv
// Package: types, constants and helper functions for the float32 stream statistics block.
package fss_pkg;
    localparam int INDEX_WIDTH = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] PLUS_INF  = 32'h7F80_0000;
    localparam logic [31:0] MINUS_INF = 32'hFF80_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [INDEX_WIDTH-1:0] INDEX_LIMIT = '1;

    localparam logic [1:0] CLS_FINITE = 2'd0;
    localparam logic [1:0] CLS_NAN    = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [1:0]  cls;
        logic        end_of_stream;
    } t_cls_item;

    typedef struct packed {
        logic [31:0] element_count;
        logic [31:0] nan_total;
        logic [31:0] inf_total;
        logic [31:0] min_bits;
        logic [31:0] max_bits;
        logic [31:0] max_abs_bits;
        logic        nan_seen;
        logic [31:0] first_nan_index;
        logic        inf_seen;
        logic [31:0] first_inf_index;
    } t_out_item;

    // a < b in float order for non-NaN words, with both zeros equal
    function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
        logic a_neg, b_neg, a_zero, b_zero;
        a_neg  = a[31];
        b_neg  = b[31];
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        if (a_zero && b_zero) return 1'b0;
        if (a_neg != b_neg) return a_neg && !(a_zero && b_zero);
        if (a_neg) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    function automatic logic [31:0] f_sat_inc(input logic [31:0] c);
        return (c == ALL_ONES) ? c : c + 32'd1;
    endfunction
endpackage

### sv/fss_if.sv
// Interfaces: valid/ready channels for input words and result records.
interface fss_in_if;
    logic               valid;
    logic               ready;
    fss_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface fss_out_if;
    logic               valid;
    logic               ready;
    fss_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### sv/fss_front.sv
// Front end: accepts words, classifies them and pushes them into a small queue.
module fss_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fss_in_if.sink               in_ch,
    output fss_pkg::t_cls_item   o_item,
    output logic                 o_valid,
    input  logic                 i_pop
);
    import fss_pkg::*;

    t_cls_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wp, n_wp, r_rp, n_rp;
    logic [QUEUE_AW:0]     r_cnt, n_cnt;
    t_cls_item             w_item;
    logic                  w_push, w_pop;
    logic [7:0]            w_exp;

    assign w_exp = in_ch.payload.value_bits[30:23];
    always_comb begin
        w_item.value_bits    = in_ch.payload.value_bits;
        w_item.end_of_stream = in_ch.payload.end_of_stream;
        if (w_exp != 8'hFF) w_item.cls = CLS_FINITE;
        else if (in_ch.payload.value_bits[22:0] != '0) w_item.cls = CLS_NAN;
        else w_item.cls = CLS_INF;
    end

    assign in_ch.ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push = in_ch.valid && in_ch.ready;
    assign o_valid = (r_cnt != '0);
    assign w_pop  = i_pop && o_valid;
    assign o_item = r_mem[r_rp];

    always_comb begin
        n_wp  = w_push ? r_wp + QUEUE_AW'(1) : r_wp;
        n_rp  = w_pop ? r_rp + QUEUE_AW'(1) : r_rp;
        n_cnt = r_cnt + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_item;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

### sv/fss_back.sv
// Back end: updates running statistics and holds the result record for the sink.
module fss_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fss_pkg::t_cls_item   i_item,
    input  logic                 i_valid,
    output logic                 o_pop,
    fss_out_if.source            out_ch
);
    import fss_pkg::*;

    logic [31:0] r_cnt, r_nan_cnt, r_inf_cnt, r_min, r_max, r_abs, r_nan_idx, r_inf_idx;
    logic        r_nan_f, r_inf_f;
    logic [31:0] n_cnt, n_nan_cnt, n_inf_cnt, n_min, n_max, n_abs, n_nan_idx, n_inf_idx;
    logic        n_nan_f, n_inf_f;
    logic        r_ov, w_take;
    t_out_item   r_out, n_out;
    logic [31:0] w_pos, w_v, w_av;
    logic [INDEX_WIDTH-1:0] w_pos_w;

    assign o_pop  = i_valid && (!r_ov || out_ch.ready);
    assign w_take = o_pop;
    assign out_ch.valid   = r_ov;
    assign out_ch.payload = r_out;
    assign w_v  = i_item.value_bits;
    assign w_av = {1'b0, w_v[30:0]};

    always_comb begin
        if (INDEX_WIDTH >= 32) w_pos_w = INDEX_WIDTH'(r_cnt);
        else if (r_cnt > 32'(INDEX_LIMIT)) w_pos_w = INDEX_LIMIT;
        else w_pos_w = INDEX_WIDTH'(r_cnt);
        w_pos = 32'(w_pos_w);
    end

    always_comb begin
        n_cnt = f_sat_inc(r_cnt);
        n_nan_cnt = r_nan_cnt; n_inf_cnt = r_inf_cnt;
        n_min = r_min; n_max = r_max; n_abs = r_abs;
        n_nan_f = r_nan_f; n_inf_f = r_inf_f;
        n_nan_idx = r_nan_idx; n_inf_idx = r_inf_idx;
        unique case (i_item.cls)
            CLS_NAN: begin
                n_nan_cnt = f_sat_inc(r_nan_cnt);
                if (!r_nan_f) begin
                    n_nan_f = 1'b1;
                    n_nan_idx = w_pos;
                end
            end
            CLS_INF: begin
                n_inf_cnt = f_sat_inc(r_inf_cnt);
                if (!r_inf_f) begin
                    n_inf_f = 1'b1;
                    n_inf_idx = w_pos;
                end
            end
            default: begin
                if (f_less(w_v, r_min)) n_min = w_v;
                if (f_less(r_max, w_v)) n_max = w_v;
                if (w_av > r_abs) n_abs = w_av;
            end
        endcase
        n_out.element_count   = n_cnt;
        n_out.nan_total       = n_nan_cnt;
        n_out.inf_total       = n_inf_cnt;
        n_out.min_bits        = (n_min[30:23] == 8'hFF) ? '0 : n_min;
        n_out.max_bits        = (n_max[30:23] == 8'hFF) ? '0 : n_max;
        n_out.max_abs_bits    = n_abs;
        n_out.nan_seen        = n_nan_f;
        n_out.first_nan_index = n_nan_idx;
        n_out.inf_seen        = n_inf_f;
        n_out.first_inf_index = n_inf_idx;
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_item.end_of_stream) r_out <= n_out;
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_cnt <= '0; r_nan_cnt <= '0; r_inf_cnt <= '0;
            r_min <= PLUS_INF; r_max <= MINUS_INF; r_abs <= '0;
            r_nan_f <= 1'b0; r_inf_f <= 1'b0;
            r_nan_idx <= ALL_ONES; r_inf_idx <= ALL_ONES;
        end else begin
            if (w_take && i_item.end_of_stream) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
            if (w_take) begin
                if (i_item.end_of_stream) begin
                    r_cnt <= '0; r_nan_cnt <= '0; r_inf_cnt <= '0;
                    r_min <= PLUS_INF; r_max <= MINUS_INF; r_abs <= '0;
                    r_nan_f <= 1'b0; r_inf_f <= 1'b0;
                    r_nan_idx <= ALL_ONES; r_inf_idx <= ALL_ONES;
                end else begin
                    r_cnt <= n_cnt; r_nan_cnt <= n_nan_cnt; r_inf_cnt <= n_inf_cnt;
                    r_min <= n_min; r_max <= n_max; r_abs <= n_abs;
                    r_nan_f <= n_nan_f; r_inf_f <= n_inf_f;
                    r_nan_idx <= n_nan_idx; r_inf_idx <= n_inf_idx;
                end
            end
        end
    end
endmodule

### sv/float32_stream_stats_top.sv
// Top level: float32 stream statistics with a decoupled classify front and update back.
// One binary32 word is taken per cycle while the queue has room; a four-entry queue separates
// classification from the statistics update, which handles one word per cycle unless an unread
// result holds it. A word marked end_of_stream yields one result record, held in an output
// register that turns valid as the update takes that word from the queue; the statistics then
// restart for the next stream. Input stalls only when the queue fills behind an unread result.
module float32_stream_stats_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fss_in_if.sink    in_ch,
    fss_out_if.source out_ch
);
    import fss_pkg::*;

    t_cls_item w_item;
    logic      w_valid, w_pop;

    fss_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_item(w_item), .o_valid(w_valid), .i_pop(w_pop)
    );

    fss_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(w_item),
        .i_valid(w_valid), .o_pop(w_pop), .out_ch(out_ch)
    );
endmodule
